// ===== hw/rtl/windowed_effort_average_defines.svh =====
// assertion macros for the windowed effort averager
// no dependencies; included by files that carry concurrent checks
`ifndef WINDOWED_EFFORT_AVERAGE_DEFINES_SVH
`define WINDOWED_EFFORT_AVERAGE_DEFINES_SVH
`ifndef SYNTHESIS
`define WEA_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("windowed_effort_average: invariant violated");
`define WEA_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("windowed_effort_average: implication violated");
`define WEA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("windowed_effort_average: next-cycle check violated");
`else
`define WEA_ASSERT_ALWAYS(label, clk, rstn, cond)
`define WEA_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define WEA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/wea_pkg.sv =====
// shared types and fixed field widths for the windowed effort averager
// no dependencies
package wea_pkg;

    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 7;
    localparam int WL_W             = 7;
    localparam int JC_W             = 4;
    localparam int SAMP_W           = 7;
    localparam int NUM_EFFORT_PORTS = 8;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [JC_W-1:0]      joint_cnt_t;

    localparam cfg_idx_t CFG_WINDOW_LENGTH = 1'd0;
    localparam cfg_idx_t CFG_INIT_JOINTS   = 1'd1;

endpackage

// ===== hw/rtl/wea_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module wea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/windowed_effort_average.sv =====
// windowed effort average: each accepted item passes through check, then per evicted slot
// an evict step and check again, then store, load, the bit-serial restoring dividers (all joints
// in parallel; skipped when the window holds no present sample) and done, where it waits for
// the result slot; s_ready is high only in idle, so a new item waits until the last is through.
// reset: synchronous active-low aresetn; no ram clearing pass, the block is ready at once.
`include "windowed_effort_average_defines.svh"

module windowed_effort_average #(
    parameter int MAX_WINDOW  = 64,
    parameter int MAX_JOINTS  = 8,
    parameter int EFFORT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_we,
    input  wea_pkg::cfg_idx_t                     cfg_index,
    input  logic [wea_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wea_pkg::JC_W-1:0]              s_joint_count,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_0,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_1,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_2,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_3,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_4,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_5,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_6,
    input  logic signed [EFFORT_BITS-1:0]         s_effort_7,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [wea_pkg::JC_W-1:0]              m_held_joints,
    output logic [wea_pkg::SAMP_W-1:0]            m_samples_averaged,
    output logic signed [EFFORT_BITS-1:0]         m_avg_0,
    output logic signed [EFFORT_BITS-1:0]         m_avg_1,
    output logic signed [EFFORT_BITS-1:0]         m_avg_2,
    output logic signed [EFFORT_BITS-1:0]         m_avg_3,
    output logic signed [EFFORT_BITS-1:0]         m_avg_4,
    output logic signed [EFFORT_BITS-1:0]         m_avg_5,
    output logic signed [EFFORT_BITS-1:0]         m_avg_6,
    output logic signed [EFFORT_BITS-1:0]         m_avg_7
);

    localparam int EB = EFFORT_BITS;
    localparam int MJ = MAX_JOINTS;
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FW = $clog2(MAX_WINDOW + 1);
    localparam int SW = EB + FW;
    localparam int CW = $clog2(SW);
    localparam int RW = MJ * EB + 1;
    localparam int JC_W = wea_pkg::JC_W;
    localparam int NP = wea_pkg::NUM_EFFORT_PORTS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_EVICT = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    function automatic wea_pkg::joint_cnt_t clamp_joints(input wea_pkg::joint_cnt_t v);
        wea_pkg::joint_cnt_t r;
        if (v == '0) begin
            r = JC_W'(1);
        end else if (int'(v) > MJ) begin
            r = JC_W'(MJ);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // control state
    logic [2:0]                state_reg, state_next;
    logic                      m_valid_reg, m_valid_next;
    logic [FW-1:0]             fill_reg, fill_next;
    logic [AW-1:0]             oldest_reg, oldest_next;
    logic [FW-1:0]             present_reg, present_next;
    wea_pkg::joint_cnt_t       held_reg, held_next;
    logic                      took_reg, took_next;
    logic [wea_pkg::WL_W-1:0]  wl_reg, wl_next;
    logic signed [SW-1:0]      sum_reg [MJ];
    logic signed [SW-1:0]      sum_next [MJ];

    // payload
    wea_pkg::joint_cnt_t       count_reg, count_next;
    logic signed [EB-1:0]      eff_reg [MJ];
    logic signed [EB-1:0]      eff_next [MJ];
    logic [SW-1:0]             dvd_reg [MJ];
    logic [SW-1:0]             dvd_next [MJ];
    logic [FW-1:0]             rem_reg [MJ];
    logic [FW-1:0]             rem_next [MJ];
    logic                      neg_reg [MJ];
    logic                      neg_next [MJ];
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [EB-1:0]      avg_reg [MJ];
    logic signed [EB-1:0]      avg_next [MJ];
    wea_pkg::joint_cnt_t       held_out_reg, held_out_next;
    logic [wea_pkg::SAMP_W-1:0] samples_reg, samples_next;

    logic signed [EB-1:0]      eff_in [NP];
    logic signed [EB-1:0]      avg_out [NP];
    logic [FW-1:0]             win_eff;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [RW-1:0]             ram_wdata;
    logic [RW-1:0]             ram_rdata;

    assign eff_in[0] = s_effort_0;
    assign eff_in[1] = s_effort_1;
    assign eff_in[2] = s_effort_2;
    assign eff_in[3] = s_effort_3;
    assign eff_in[4] = s_effort_4;
    assign eff_in[5] = s_effort_5;
    assign eff_in[6] = s_effort_6;
    assign eff_in[7] = s_effort_7;

    assign win_eff = (wl_reg == '0) ? FW'(1)
                   : ((int'(wl_reg) > MAX_WINDOW) ? FW'(MAX_WINDOW) : FW'(wl_reg));

    // one ram row per slot: present flag on top, joint efforts below
    always_comb begin
        for (int j = 0; j < MJ; j++) begin
            ram_wdata[j*EB +: EB] = eff_reg[j];
        end
        ram_wdata[RW-1] = (count_reg != '0);
    end

    wea_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WINDOW)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        wea_pkg::joint_cnt_t  cnt_c;
        logic signed [EB-1:0] lane;
        logic [FW:0]          rem_sh;
        logic [SW-1:0]        mag;
        logic [EB-1:0]        q;
        int                   t;

        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        present_next  = present_reg;
        held_next     = held_reg;
        took_next     = took_reg;
        wl_next       = wl_reg;
        count_next    = count_reg;
        cnt_next      = cnt_reg;
        held_out_next = held_out_reg;
        samples_next  = samples_reg;
        for (int j = 0; j < MJ; j++) begin
            sum_next[j] = sum_reg[j];
            eff_next[j] = eff_reg[j];
            dvd_next[j] = dvd_reg[j];
            rem_next[j] = rem_reg[j];
            neg_next[j] = neg_reg[j];
            avg_next[j] = avg_reg[j];
        end
        ram_we    = 1'b0;
        ram_waddr = oldest_reg;
        cnt_c     = '0;
        lane      = '0;
        rem_sh    = '0;
        mag       = '0;
        q         = '0;
        t         = 0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            unique case (cfg_index)
                wea_pkg::CFG_WINDOW_LENGTH: begin
                    wl_next = cfg_data[wea_pkg::WL_W-1:0];
                end
                wea_pkg::CFG_INIT_JOINTS: begin
                    if (!took_reg) begin
                        held_next = clamp_joints(cfg_data[JC_W-1:0]);
                    end
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_c = (int'(s_joint_count) > MJ) ? JC_W'(MJ) : s_joint_count;
                    count_next = cnt_c;
                    for (int j = 0; j < MJ; j++) begin
                        eff_next[j] = (JC_W'(j) < cnt_c) ? eff_in[j] : '0;
                    end
                    if (cnt_c != '0) begin
                        took_next = 1'b1;
                        // new joint layout restarts the window
                        if (cnt_c != held_reg) begin
                            held_next    = cnt_c;
                            fill_next    = '0;
                            oldest_next  = '0;
                            present_next = '0;
                            for (int j = 0; j < MJ; j++) begin
                                sum_next[j] = '0;
                            end
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // ram read of the oldest slot is issued this cycle
                if (fill_reg != '0 && fill_reg >= win_eff) begin
                    state_next = ST_EVICT;
                end else begin
                    state_next = ST_STORE;
                end
            end
            ST_EVICT: begin
                if (ram_rdata[RW-1]) begin
                    for (int j = 0; j < MJ; j++) begin
                        lane = ram_rdata[j*EB +: EB];
                        sum_next[j] = sum_reg[j] - SW'(lane);
                    end
                    if (present_reg != '0) begin
                        present_next = present_reg - 1'b1;
                    end
                end
                oldest_next = (int'(oldest_reg) == MAX_WINDOW - 1) ? '0
                            : oldest_reg + 1'b1;
                fill_next  = fill_reg - 1'b1;
                state_next = ST_CHECK;
            end
            ST_STORE: begin
                t = int'(oldest_reg) + int'(fill_reg);
                if (t >= MAX_WINDOW) begin
                    t = t - MAX_WINDOW;
                end
                ram_we    = 1'b1;
                ram_waddr = AW'(t);
                for (int j = 0; j < MJ; j++) begin
                    sum_next[j] = sum_reg[j] + SW'(eff_reg[j]);
                end
                if (count_reg != '0) begin
                    present_next = present_reg + 1'b1;
                end
                fill_next  = fill_reg + 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (present_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    for (int j = 0; j < MJ; j++) begin
                        neg_next[j] = sum_reg[j][SW-1];
                        dvd_next[j] = sum_reg[j][SW-1] ? SW'(-sum_reg[j]) : SW'(sum_reg[j]);
                        rem_next[j] = '0;
                    end
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // restoring division, quotient bits shift into the dividend register
                for (int j = 0; j < MJ; j++) begin
                    rem_sh = {rem_reg[j], dvd_reg[j][SW-1]};
                    if (rem_sh >= {1'b0, present_reg}) begin
                        rem_next[j] = FW'(rem_sh - {1'b0, present_reg});
                        dvd_next[j] = {dvd_reg[j][SW-2:0], 1'b1};
                    end else begin
                        rem_next[j] = rem_sh[FW-1:0];
                        dvd_next[j] = {dvd_reg[j][SW-2:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(SW - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    held_out_next = held_reg;
                    samples_next  = wea_pkg::SAMP_W'(present_reg);
                    for (int j = 0; j < MJ; j++) begin
                        mag = dvd_reg[j];
                        q   = mag[EB-1:0];
                        if (present_reg != '0 && JC_W'(j) < held_reg) begin
                            avg_next[j] = neg_reg[j] ? -q : q;
                        end else begin
                            avg_next[j] = '0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            present_reg <= '0;
            held_reg    <= JC_W'(MJ);
            took_reg    <= 1'b0;
            wl_reg      <= wea_pkg::WL_W'(1);
            for (int j = 0; j < MJ; j++) begin
                sum_reg[j] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            present_reg <= present_next;
            held_reg    <= held_next;
            took_reg    <= took_next;
            wl_reg      <= wl_next;
            for (int j = 0; j < MJ; j++) begin
                sum_reg[j] <= sum_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        count_reg    <= count_next;
        cnt_reg      <= cnt_next;
        held_out_reg <= held_out_next;
        samples_reg  <= samples_next;
        for (int j = 0; j < MJ; j++) begin
            eff_reg[j] <= eff_next[j];
            dvd_reg[j] <= dvd_next[j];
            rem_reg[j] <= rem_next[j];
            neg_reg[j] <= neg_next[j];
            avg_reg[j] <= avg_next[j];
        end
    end

    for (genvar g = 0; g < NP; g++) begin : g_avg_out
        if (g < MJ) begin : g_used
            assign avg_out[g] = avg_reg[g];
        end else begin : g_unused
            assign avg_out[g] = '0;
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_held_joints      = held_out_reg;
    assign m_samples_averaged = samples_reg;
    assign m_avg_0            = avg_out[0];
    assign m_avg_1            = avg_out[1];
    assign m_avg_2            = avg_out[2];
    assign m_avg_3            = avg_out[3];
    assign m_avg_4            = avg_out[4];
    assign m_avg_5            = avg_out[5];
    assign m_avg_6            = avg_out[6];
    assign m_avg_7            = avg_out[7];

    `WEA_ASSERT_ALWAYS(a_present_within_fill, aclk, aresetn, present_reg <= fill_reg)
    `WEA_ASSERT_IMPLIES(a_store_has_room, aclk, aresetn, state_reg == ST_STORE, fill_reg < win_eff)
    `WEA_ASSERT_IMPLIES(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, present_reg != '0)
    `WEA_ASSERT_NEXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready, state_reg == ST_CHECK)

endmodule
